FILE: rtl/scbc_pkg.sv
// ----------------------------------------------------------------------------
// scbc_pkg
// Codes, register indexes, reset values and arithmetic constants of the
// sensor calibration button controller.
// ----------------------------------------------------------------------------
package scbc_pkg;

    // Item opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // Calibration events
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_LED_TEST = 3'd1;
    localparam logic [2:0] EV_PH4_OK   = 3'd2;
    localparam logic [2:0] EV_PH7_OK   = 3'd3;
    localparam logic [2:0] EV_PH_FAIL  = 3'd4;
    localparam logic [2:0] EV_EC_OK    = 3'd5;
    localparam logic [2:0] EV_EC_FAIL  = 3'd6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACID_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACID_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUT_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUT_HIGH   = 3'd6;

    // Configuration reset values
    localparam logic [15:0] RST_SHORT_PRESS = 16'd3000;
    localparam logic [15:0] RST_LONG_PRESS  = 16'd10000;
    localparam logic [11:0] RST_LED_TIMEOUT = 12'd3000;
    localparam logic [11:0] RST_ACID_LOW    = 12'd1150;
    localparam logic [11:0] RST_ACID_HIGH   = 12'd1250;
    localparam logic [11:0] RST_NEUT_LOW    = 12'd975;
    localparam logic [11:0] RST_NEUT_HIGH   = 12'd1075;

    // Indicator timers and the LEDs each one owns (bit0 pH4 .. bit3 fail)
    localparam int unsigned NTIMERS = 5;
    localparam int unsigned T_TEST = 0;
    localparam int unsigned T_PH4  = 1;
    localparam int unsigned T_PH7  = 2;
    localparam int unsigned T_EC   = 3;
    localparam int unsigned T_FAIL = 4;
    localparam logic [3:0] TIMER_LED [NTIMERS] = '{4'hF, 4'h1, 4'h2, 4'h4, 4'h8};

    // pH fallback values
    localparam logic [11:0] ACID_DEFAULT_MV = 12'd1200;
    localparam logic [11:0] NEUT_DEFAULT_MV = 12'd1024;

    // Conductivity arithmetic: K = 1413*128*S / (1375*mv)
    localparam int unsigned SER_W = 19;                  // bits of S
    localparam int unsigned NUM_W = 37;                  // numerator
    localparam int unsigned DEN_W = 27;                  // denominator
    localparam int unsigned Q_W   = 18;                  // quotient, top bit overflow
    localparam int unsigned DVS_W = DEN_W + Q_W - 1;     // aligned divisor
    localparam int unsigned CNT_W = 5;
    localparam logic [NUM_W-1:0] NUM_COEF = NUM_W'(1413 * 128);
    localparam logic [DEN_W-1:0] DEN_COEF = DEN_W'(1375);
    localparam logic [Q_W-1:0]   K_MIN_FLOOR = Q_W'(1228);   // 0.3 * 4096 rounded down
    localparam logic [Q_W-1:0]   K_MAX = Q_W'(40960);        // 10.0 * 4096
    localparam logic [15:0]      K_DEFAULT = 16'd4096;       // 1.0
    localparam logic [11:0]      EC_READ_MIN = 12'd300;
    localparam logic [11:0]      EC_READ_MAX = 12'd1900;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

FILE: rtl/sensor_calibration_button_controller_top.sv
// ----------------------------------------------------------------------------
// sensor_calibration_button_controller_top
// Button hold timing, indicator timers and pH / conductivity calibration.
// ----------------------------------------------------------------------------
// Each input word is a millisecond tick, a button press or a button release,
// carrying the current sensor readings; every word yields exactly one result
// word holding the indicator drives, the calibration event, the stored
// calibration values, a store strobe and a timer-running flag. Ticks, presses,
// short-hold releases (LED test) and middle-hold releases (pH calibration) are
// finished in the cycle they are accepted, so such words can be taken every
// cycle while the result side keeps up. A long-hold release (conductivity
// calibration) runs a bit-serial multiplication, one bit of the 19-bit
// compensated reading per cycle, forming numerator and denominator together,
// then a restoring divider producing one quotient bit per cycle, and a final
// state that range-checks and commits once the result side is free. No word
// is accepted until the block is idle again. The configuration port is
// always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module sensor_calibration_button_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [11:0]                       i_ph_adc,
    input  logic [11:0]                       i_ec_reading,
    input  logic signed [11:0]                i_water_temp,
    input  logic                              i_temp_error,
    input  logic [15:0]                       i_ec_millivolts,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_led_ph4,
    output logic                              o_led_ph7,
    output logic                              o_led_ec,
    output logic                              o_led_fail,
    output logic [2:0]                        o_calib_event,
    output logic [11:0]                       o_acid_cal_mv,
    output logic [11:0]                       o_neutral_cal_mv,
    output logic [15:0]                       o_cell_constant,
    output logic                              o_store_request,
    output logic                              o_any_active
);
    import scbc_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_event, n_event;
    logic                r_store, n_store;

    logic [15:0]         r_cfg_short, n_cfg_short;
    logic [15:0]         r_cfg_long, n_cfg_long;
    logic [11:0]         r_cfg_timeout, n_cfg_timeout;
    logic [11:0]         r_cfg_acid_lo, n_cfg_acid_lo;
    logic [11:0]         r_cfg_acid_hi, n_cfg_acid_hi;
    logic [11:0]         r_cfg_neut_lo, n_cfg_neut_lo;
    logic [11:0]         r_cfg_neut_hi, n_cfg_neut_hi;

    logic [15:0]         r_hold, n_hold;
    logic                r_press, n_press;
    logic [3:0]          r_led, n_led;
    logic [NTIMERS-1:0]  r_tact, n_tact;
    logic [11:0]         r_tleft [NTIMERS];
    logic [11:0]         n_tleft [NTIMERS];
    logic [11:0]         r_acid, n_acid;
    logic [11:0]         r_neut, n_neut;
    logic [15:0]         r_kconst, n_kconst;

    // serial datapath (payload, no reset)
    logic [SER_W-1:0]    r_sreg, n_sreg;
    logic [SER_W-1:0]    r_mreg, n_mreg;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [DVS_W-1:0]    r_dvs, n_dvs;
    logic [Q_W-1:0]      r_q, n_q;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_bad, n_bad;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic w_out_free;
    logic w_accept;
    logic w_cfg_we;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != ST_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we   = i_cfg_valid;

    // ------------------------------------------------------------------
    // Per-word arithmetic
    // ------------------------------------------------------------------
    logic [11:0]          w_tload;
    logic [23:0]          w_mv_full;
    logic [11:0]          w_mv;
    logic                 w_in_acid;
    logic                 w_in_neut;
    logic signed [12:0]   w_temp;
    logic signed [12:0]   w_tdiff;
    logic signed [20:0]   w_s;
    logic                 w_ec_bad;

    // a zero timeout still expires on the next tick
    assign w_tload = (r_cfg_timeout == 12'd0) ? 12'd1 : r_cfg_timeout;

    // ADC code to millivolts, 3300 mV full scale over 4096 codes
    assign w_mv_full = {12'd0, i_ph_adc} * 24'd3300;
    assign w_mv      = w_mv_full[23:12];
    assign w_in_acid = (w_mv >= r_cfg_acid_lo) && (w_mv <= r_cfg_acid_hi);
    assign w_in_neut = (w_mv >= r_cfg_neut_lo) && (w_mv <= r_cfg_neut_hi);

    // temperature compensation term, 25 C substitutes a failed sensor
    assign w_temp  = i_temp_error ? 13'sd400 : {i_water_temp[11], i_water_temp};
    assign w_tdiff = w_temp - 13'sd400;
    assign w_s     = 21'sd160000 + 21'sd185 * 21'(w_tdiff);
    assign w_ec_bad = (i_ec_reading < EC_READ_MIN) || (i_ec_reading > EC_READ_MAX)
                   || (i_ec_millivolts == 16'd0) || (w_s <= 21'sd0);

    // ------------------------------------------------------------------
    // Quotient range check
    // ------------------------------------------------------------------
    logic [29:0] w_rem5;
    logic [29:0] w_den4;
    logic        w_lo_ok;
    logic        w_hi_ok;
    logic        w_ec_pass;

    // the remainder is below the divisor, so it fits the divisor's width
    assign w_rem5 = (30'(r_num[DEN_W-1:0]) << 2) + 30'(r_num[DEN_W-1:0]);
    assign w_den4 = 30'(r_den) << 2;
    // K >= 0.3*4096: above the floor, or on it with a fraction of at least 0.8
    assign w_lo_ok = (r_q > K_MIN_FLOOR) || ((r_q == K_MIN_FLOOR) && (w_rem5 >= w_den4));
    assign w_hi_ok = (r_q < K_MAX) || ((r_q == K_MAX) && (r_num == '0));
    assign w_ec_pass = !r_bad && w_lo_ok && w_hi_ok;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic w_out_load;
    logic w_div_ge;

    assign w_div_ge = {{(DVS_W-NUM_W){1'b0}}, r_num} >= r_dvs;

    always_comb begin
        n_state     = r_state;
        n_event     = r_event;
        n_store     = r_store;
        n_hold      = r_hold;
        n_press     = r_press;
        n_led       = r_led;
        n_tact      = r_tact;
        n_tleft     = r_tleft;
        n_acid      = r_acid;
        n_neut      = r_neut;
        n_kconst    = r_kconst;
        n_sreg      = r_sreg;
        n_mreg      = r_mreg;
        n_num       = r_num;
        n_den       = r_den;
        n_dvs       = r_dvs;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_bad       = r_bad;
        w_out_load  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_event = EV_NONE;
                    n_store = 1'b0;
                    w_out_load = 1'b1;
                    unique case (i_opcode)
                        OP_TICK: begin
                            if (r_press && (r_hold != 16'hFFFF)) begin
                                n_hold = r_hold + 16'd1;
                            end
                            // count down running timers, drop their LEDs on expiry
                            for (int t = 0; t < NTIMERS; t++) begin
                                if (r_tact[t]) begin
                                    if (r_tleft[t] <= 12'd1) begin
                                        n_tleft[t] = 12'd0;
                                        n_tact[t]  = 1'b0;
                                        n_led      = n_led & ~TIMER_LED[t];
                                    end else begin
                                        n_tleft[t] = r_tleft[t] - 12'd1;
                                    end
                                end
                            end
                        end
                        OP_PRESS: begin
                            n_hold  = 16'd0;
                            n_press = 1'b1;
                        end
                        OP_RELEASE: begin
                            if (r_press) begin
                                n_press = 1'b0;
                                if (r_hold < r_cfg_short) begin
                                    n_tact[T_TEST]  = 1'b1;
                                    n_tleft[T_TEST] = w_tload;
                                    n_led   = n_led | TIMER_LED[T_TEST];
                                    n_event = EV_LED_TEST;
                                end else if (r_hold < r_cfg_long) begin
                                    n_store = 1'b1;
                                    if (w_in_acid) begin
                                        n_acid = w_mv;
                                        n_tact[T_PH4]  = 1'b1;
                                        n_tleft[T_PH4] = w_tload;
                                        n_led   = n_led | TIMER_LED[T_PH4];
                                        n_event = EV_PH4_OK;
                                    end else if (w_in_neut) begin
                                        n_neut = w_mv;
                                        n_tact[T_PH7]  = 1'b1;
                                        n_tleft[T_PH7] = w_tload;
                                        n_led   = n_led | TIMER_LED[T_PH7];
                                        n_event = EV_PH7_OK;
                                    end else begin
                                        n_acid = ACID_DEFAULT_MV;
                                        n_neut = NEUT_DEFAULT_MV;
                                        n_tact[T_FAIL]  = 1'b1;
                                        n_tleft[T_FAIL] = w_tload;
                                        n_led   = n_led | TIMER_LED[T_FAIL];
                                        n_event = EV_PH_FAIL;
                                    end
                                end else begin
                                    // hand over to the serial conductivity datapath
                                    w_out_load = 1'b0;
                                    n_sreg  = w_s[SER_W-1:0];
                                    n_mreg  = {{(SER_W-16){1'b0}}, i_ec_millivolts};
                                    n_num   = '0;
                                    n_den   = '0;
                                    n_q     = '0;
                                    n_cnt   = '0;
                                    n_bad   = w_ec_bad;
                                    n_state = ST_MUL;
                                end
                            end
                        end
                        default: begin
                            // unused opcode: report the state unchanged
                        end
                    endcase
                end
            end
            ST_MUL: begin
                // MSB first: shift the partial product, add the coefficient per set bit
                n_num  = {r_num[NUM_W-2:0], 1'b0} + (r_sreg[SER_W-1] ? NUM_COEF : '0);
                n_den  = {r_den[DEN_W-2:0], 1'b0} + (r_mreg[SER_W-1] ? DEN_COEF : '0);
                n_sreg = {r_sreg[SER_W-2:0], 1'b0};
                n_mreg = {r_mreg[SER_W-2:0], 1'b0};
                if (r_cnt == CNT_W'(SER_W - 1)) begin
                    n_dvs   = {n_den, {(Q_W-1){1'b0}}};
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_DIV: begin
                // restoring step: one quotient bit, remainder kept in r_num
                if (w_div_ge) begin
                    n_num = r_num - r_dvs[NUM_W-1:0];
                end
                n_q   = {r_q[Q_W-2:0], w_div_ge};
                n_dvs = r_dvs >> 1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_store = 1'b1;
                    if (w_ec_pass) begin
                        n_kconst = r_q[15:0];
                        n_tact[T_EC]  = 1'b1;
                        n_tleft[T_EC] = w_tload;
                        n_led   = r_led | TIMER_LED[T_EC];
                        n_event = EV_EC_OK;
                    end else begin
                        n_kconst = K_DEFAULT;
                        n_tact[T_FAIL]  = 1'b1;
                        n_tleft[T_FAIL] = w_tload;
                        n_led   = r_led | TIMER_LED[T_FAIL];
                        n_event = EV_EC_FAIL;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // result word: load on completion, drop once taken
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // configuration writes, masked to register width; indexes past the list drop
    always_comb begin
        n_cfg_short   = r_cfg_short;
        n_cfg_long    = r_cfg_long;
        n_cfg_timeout = r_cfg_timeout;
        n_cfg_acid_lo = r_cfg_acid_lo;
        n_cfg_acid_hi = r_cfg_acid_hi;
        n_cfg_neut_lo = r_cfg_neut_lo;
        n_cfg_neut_hi = r_cfg_neut_hi;
        if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SHORT_PRESS: n_cfg_short   = i_cfg_data;
                CFG_LONG_PRESS:  n_cfg_long    = i_cfg_data;
                CFG_LED_TIMEOUT: n_cfg_timeout = i_cfg_data[11:0];
                CFG_ACID_LOW:    n_cfg_acid_lo = i_cfg_data[11:0];
                CFG_ACID_HIGH:   n_cfg_acid_hi = i_cfg_data[11:0];
                CFG_NEUT_LOW:    n_cfg_neut_lo = i_cfg_data[11:0];
                CFG_NEUT_HIGH:   n_cfg_neut_hi = i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flip-flops
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_cfg_short   <= RST_SHORT_PRESS;
            r_cfg_long    <= RST_LONG_PRESS;
            r_cfg_timeout <= RST_LED_TIMEOUT;
            r_cfg_acid_lo <= RST_ACID_LOW;
            r_cfg_acid_hi <= RST_ACID_HIGH;
            r_cfg_neut_lo <= RST_NEUT_LOW;
            r_cfg_neut_hi <= RST_NEUT_HIGH;
            r_hold        <= 16'd0;
            r_press       <= 1'b0;
            r_led         <= 4'd0;
            r_tact        <= '0;
            for (int t = 0; t < NTIMERS; t++) begin
                r_tleft[t] <= 12'd0;
            end
            r_acid        <= 12'd0;
            r_neut        <= 12'd0;
            r_kconst      <= 16'd0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_cfg_short   <= n_cfg_short;
            r_cfg_long    <= n_cfg_long;
            r_cfg_timeout <= n_cfg_timeout;
            r_cfg_acid_lo <= n_cfg_acid_lo;
            r_cfg_acid_hi <= n_cfg_acid_hi;
            r_cfg_neut_lo <= n_cfg_neut_lo;
            r_cfg_neut_hi <= n_cfg_neut_hi;
            r_hold        <= n_hold;
            r_press       <= n_press;
            r_led         <= n_led;
            r_tact        <= n_tact;
            r_tleft       <= n_tleft;
            r_acid        <= n_acid;
            r_neut        <= n_neut;
            r_kconst      <= n_kconst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_event <= n_event;
        r_store <= n_store;
        r_sreg  <= n_sreg;
        r_mreg  <= n_mreg;
        r_num   <= n_num;
        r_den   <= n_den;
        r_dvs   <= n_dvs;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_bad   <= n_bad;
    end

    // ------------------------------------------------------------------
    // Outputs: state only moves when the next word is taken, which needs
    // the present result gone, so the state registers drive the result
    // ------------------------------------------------------------------
    assign o_valid          = r_out_valid;
    assign o_led_ph4        = r_led[0];
    assign o_led_ph7        = r_led[1];
    assign o_led_ec         = r_led[2];
    assign o_led_fail       = r_led[3];
    assign o_calib_event    = r_event;
    assign o_acid_cal_mv    = r_acid;
    assign o_neutral_cal_mv = r_neut;
    assign o_cell_constant  = r_kconst;
    assign o_store_request  = r_store;
    assign o_any_active     = |r_tact;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor calibration button controller.
// ----------------------------------------------------------------------------
// Words are offered on the input channel. A monitor runs every accepted word
// through a behavioural predictor of the controller, which tracks hold time,
// indicator timers and the stored calibration values. The predictor queues
// one expected readout per word. Each accepted result word is checked field
// by field against the oldest queued readout. A short directed table comes
// first. Random button sequences follow, under several register settings and
// idling patterns. The run ends with both hold thresholds at their top.
// ----------------------------------------------------------------------------
module tb_top;
    import scbc_pkg::*;

    // Opcode 3 has no function in the block; it must leave the state alone
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [11:0]        ph_adc;
        logic [11:0]        ec_reading;
        logic signed [11:0] water_temp;
        logic               temp_error;
        logic [15:0]        ec_mv;
    } t_word;

    typedef struct packed {
        logic        led_ph4;
        logic        led_ph7;
        logic        led_ec;
        logic        led_fail;
        logic [2:0]  calib_event;
        logic [11:0] acid_mv;
        logic [11:0] neutral_mv;
        logic [15:0] cell_k;
        logic        store_req;
        logic        any_active;
    } t_result;

    // A typed row carries its own readout; an untyped row is left to the predictor
    typedef struct packed {
        logic    typed;
        t_result r;
    } t_note;

    typedef struct {
        t_word   w;
        logic    typed;
        t_result r;
    } t_row;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_opcode = OP_TICK;
    logic [11:0]           i_ph_adc = '0;
    logic [11:0]           i_ec_reading = '0;
    logic signed [11:0]    i_water_temp = '0;
    logic                  i_temp_error = 1'b0;
    logic [15:0]           i_ec_millivolts = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_led_ph4;
    logic                  o_led_ph7;
    logic                  o_led_ec;
    logic                  o_led_fail;
    logic [2:0]            o_calib_event;
    logic [11:0]           o_acid_cal_mv;
    logic [11:0]           o_neutral_cal_mv;
    logic [15:0]           o_cell_constant;
    logic                  o_store_request;
    logic                  o_any_active;

    sensor_calibration_button_controller_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_ph_adc        (i_ph_adc),
        .i_ec_reading    (i_ec_reading),
        .i_water_temp    (i_water_temp),
        .i_temp_error    (i_temp_error),
        .i_ec_millivolts (i_ec_millivolts),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_led_ph4       (o_led_ph4),
        .o_led_ph7       (o_led_ph7),
        .o_led_ec        (o_led_ec),
        .o_led_fail      (o_led_fail),
        .o_calib_event   (o_calib_event),
        .o_acid_cal_mv   (o_acid_cal_mv),
        .o_neutral_cal_mv(o_neutral_cal_mv),
        .o_cell_constant (o_cell_constant),
        .o_store_request (o_store_request),
        .o_any_active    (o_any_active)
    );

    // 12 ns period: 6 ns low, 6 ns high
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register copies and the controller's own state
    // ------------------------------------------------------------------------
    logic [15:0] cfg_reg [7] = '{RST_SHORT_PRESS, RST_LONG_PRESS, 16'(RST_LED_TIMEOUT),
                                 16'(RST_ACID_LOW), 16'(RST_ACID_HIGH),
                                 16'(RST_NEUT_LOW), 16'(RST_NEUT_HIGH)};
    logic [15:0] hold_ms = '0;
    logic        press_held = 1'b0;
    logic [3:0]  led_bits = '0;
    logic        tmr_on [NTIMERS] = '{default: 1'b0};
    logic [11:0] tmr_left [NTIMERS] = '{default: '0};
    logic [11:0] acid_mv = '0;
    logic [11:0] neutral_mv = '0;
    logic [15:0] cell_k = '0;

    t_note   offered_words [$];
    t_result expected_readouts [$];
    t_row    dir_rows [$];

    int errors = 0;
    int n_checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d (result %0d, %0t)",
                 what, got, want, n_checked, $realtime);
    endtask

    // Load a timer; a zero timeout still expires on the next tick
    function automatic void arm_timer(int unsigned t);
        tmr_on[t] = 1'b1;
        tmr_left[t] = (cfg_reg[CFG_LED_TIMEOUT][11:0] == 0) ? 12'd1
                                                            : cfg_reg[CFG_LED_TIMEOUT][11:0];
        led_bits |= TIMER_LED[t];
    endfunction

    function automatic t_result calib_predict(t_word w);
        t_result            r;
        logic [11:0]        mv;
        longint             temp_c;
        longint             slope;
        longint unsigned    num;
        longint unsigned    den;
        logic               ec_ok;
        r = '0;
        r.calib_event = EV_NONE;
        case (w.opcode)
            OP_TICK: begin
                if (press_held && hold_ms != 16'hFFFF) hold_ms++;
                for (int k = 0; k < NTIMERS; k++) begin
                    if (tmr_on[k]) begin
                        if (tmr_left[k] != 0) tmr_left[k]--;
                        if (tmr_left[k] == 0) begin
                            tmr_on[k] = 1'b0;
                            led_bits &= ~TIMER_LED[k];
                        end
                    end
                end
            end
            OP_PRESS: begin
                hold_ms = '0;
                press_held = 1'b1;
            end
            OP_RELEASE: begin
                if (press_held) begin
                    press_held = 1'b0;
                    if (hold_ms < cfg_reg[CFG_SHORT_PRESS]) begin
                        arm_timer(T_TEST);
                        r.calib_event = EV_LED_TEST;
                    end else if (hold_ms < cfg_reg[CFG_LONG_PRESS]) begin
                        r.store_req = 1'b1;
                        mv = 12'((32'(w.ph_adc) * 3300) >> 12);
                        if (mv >= cfg_reg[CFG_ACID_LOW] && mv <= cfg_reg[CFG_ACID_HIGH]) begin
                            acid_mv = mv;
                            arm_timer(T_PH4);
                            r.calib_event = EV_PH4_OK;
                        end else if (mv >= cfg_reg[CFG_NEUT_LOW] &&
                                     mv <= cfg_reg[CFG_NEUT_HIGH]) begin
                            neutral_mv = mv;
                            arm_timer(T_PH7);
                            r.calib_event = EV_PH7_OK;
                        end else begin
                            acid_mv = ACID_DEFAULT_MV;
                            neutral_mv = NEUT_DEFAULT_MV;
                            arm_timer(T_FAIL);
                            r.calib_event = EV_PH_FAIL;
                        end
                    end else begin
                        r.store_req = 1'b1;
                        temp_c = w.temp_error ? 64'sd400 : longint'($signed(w.water_temp));
                        slope = 160000 + 185 * (temp_c - 400);
                        ec_ok = 1'b0;
                        if (w.ec_reading >= EC_READ_MIN && w.ec_reading <= EC_READ_MAX &&
                            w.ec_mv != 0 && slope > 0) begin
                            num = longint'(slope) * 180864;
                            den = 64'(w.ec_mv) * 1375;
                            // accept 0.3 <= K/4096 <= 10 on the exact ratio
                            if (num * 10 >= den * 4096 * 3 && num <= den * 40960) begin
                                cell_k = 16'(num / den);
                                arm_timer(T_EC);
                                r.calib_event = EV_EC_OK;
                                ec_ok = 1'b1;
                            end
                        end
                        if (!ec_ok) begin
                            cell_k = K_DEFAULT;
                            arm_timer(T_FAIL);
                            r.calib_event = EV_EC_FAIL;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.led_ph4 = led_bits[0];
        r.led_ph7 = led_bits[1];
        r.led_ec = led_bits[2];
        r.led_fail = led_bits[3];
        r.acid_mv = acid_mv;
        r.neutral_mv = neutral_mv;
        r.cell_k = cell_k;
        for (int k = 0; k < NTIMERS; k++) r.any_active |= tmr_on[k];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic t_word mk_word(logic [1:0] op, int adc, int rd, int temp,
                                      bit terr, int mvq);
        t_word w;
        w.opcode = op;
        w.ph_adc = 12'(adc);
        w.ec_reading = 12'(rd);
        w.water_temp = 12'(temp);
        w.temp_error = terr;
        w.ec_mv = 16'(mvq);
        return w;
    endfunction

    // Readout with no calibration stored yet: only the indicators and the event
    function automatic t_result bare_result(logic [3:0] leds, logic [2:0] ev);
        t_result r;
        r = '0;
        {r.led_fail, r.led_ec, r.led_ph7, r.led_ph4} = leds;
        r.calib_event = ev;
        r.any_active = |leds;
        return r;
    endfunction

    function automatic t_word rand_word(logic [1:0] op);
        return mk_word(op, $urandom, $urandom, $urandom, 1'($urandom), $urandom);
    endfunction

    // Release word whose readings lean towards the windows and limits in force
    function automatic t_word release_word();
        t_word       w;
        int unsigned lo;
        int unsigned hi;
        int unsigned mvt;
        int          tmp;
        w = rand_word(OP_RELEASE);
        lo = 1;
        hi = 0;
        case ($urandom_range(0, 4))
            0: begin lo = cfg_reg[CFG_ACID_LOW]; hi = cfg_reg[CFG_ACID_HIGH]; end
            1: begin lo = cfg_reg[CFG_NEUT_LOW]; hi = cfg_reg[CFG_NEUT_HIGH]; end
            2: w.ph_adc = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: ;
        endcase
        if (hi > 3299) hi = 3299;
        if (lo <= hi) begin
            mvt = $urandom_range(lo, hi);
            w.ph_adc = 12'((mvt * 4096 + 3299) / 3300);
        end
        case ($urandom_range(0, 7))
            0: ;
            1: case ($urandom_range(0, 3))
                   0: w.ec_reading = EC_READ_MIN - 1;
                   1: w.ec_reading = EC_READ_MIN;
                   2: w.ec_reading = EC_READ_MAX;
                   default: w.ec_reading = EC_READ_MAX + 1;
               endcase
            default: w.ec_reading = 12'($urandom_range(300, 1900));
        endcase
        case ($urandom_range(0, 5))
            0: ;
            1: begin
                tmp = $urandom_range(400, 1024);
                w.water_temp = 12'(-tmp);
            end
            default: w.water_temp = 12'($urandom_range(0, 800));
        endcase
        w.temp_error = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
            0: ;
            1: w.ec_mv = 16'h0000;
            2: w.ec_mv = 16'hFFFF;
            default: w.ec_mv = 16'($urandom_range(500, 18000));
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_reg[idx] = (idx == CFG_SHORT_PRESS || idx == CFG_LONG_PRESS) ? 16'(val)
                                                                         : 16'(val & 12'hFFF);
    endtask

    task automatic program_config(int unsigned short_ms, int unsigned long_ms,
                                  int unsigned timeout_ms, int unsigned acid_lo,
                                  int unsigned acid_hi, int unsigned neut_lo,
                                  int unsigned neut_hi);
        cfg_write(CFG_SHORT_PRESS, short_ms);
        cfg_write(CFG_LONG_PRESS, long_ms);
        cfg_write(CFG_LED_TIMEOUT, timeout_ms);
        cfg_write(CFG_ACID_LOW, acid_lo);
        cfg_write(CFG_ACID_HIGH, acid_hi);
        cfg_write(CFG_NEUT_LOW, neut_lo);
        cfg_write(CFG_NEUT_HIGH, neut_hi);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one word and hold it until taken; valid stays high for a following word
    task automatic offer(input t_word w, input logic typed = 1'b0, input t_result r = '0);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        offered_words.push_back('{typed, r});
        i_valid <= 1'b1;
        i_opcode <= w.opcode;
        i_ph_adc <= w.ph_adc;
        i_ec_reading <= w.ec_reading;
        i_water_temp <= w.water_temp;
        i_temp_error <= w.temp_error;
        i_ec_millivolts <= w.ec_mv;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering and wait for every outstanding readout
    task automatic drain();
        i_valid <= 1'b0;
        while (offered_words.size() != 0 || expected_readouts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly press / ticks / release sequences with random content, some noise
    task automatic run_random(int n_words, int max_hold);
        int sent;
        int hold;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 99) < 15) begin
                offer(rand_word(2'($urandom_range(0, 3))));
                sent++;
            end else begin
                offer(rand_word(OP_PRESS));
                hold = $urandom_range(0, max_hold);
                repeat (hold) begin
                    // an odd press mid-hold restarts the count
                    if ($urandom_range(0, 49) == 0) offer(rand_word(OP_PRESS));
                    else offer(rand_word(OP_TICK));
                end
                offer(release_word());
                sent += hold + 2;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor and checker: predict on input words, compare on result words
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_word   seen;
        t_result got;
        t_result want;
        t_note   note;
        if (i_valid && !o_stall) begin
            seen = '{i_opcode, i_ph_adc, i_ec_reading, i_water_temp, i_temp_error,
                     i_ec_millivolts};
            want = calib_predict(seen);
            if (offered_words.size() != 0) begin
                note = offered_words.pop_front();
                if (note.typed) want = note.r;
            end
            expected_readouts.push_back(want);
        end
        if (o_valid && !i_stall) begin
            got = '{o_led_ph4, o_led_ph7, o_led_ec, o_led_fail, o_calib_event,
                    o_acid_cal_mv, o_neutral_cal_mv, o_cell_constant, o_store_request,
                    o_any_active};
            if (expected_readouts.size() == 0) begin
                flag_mismatch("result with no word pending, event", got.calib_event, -1);
            end else begin
                want = expected_readouts.pop_front();
                if (got.led_ph4 !== want.led_ph4)
                    flag_mismatch("led_ph4", got.led_ph4, want.led_ph4);
                if (got.led_ph7 !== want.led_ph7)
                    flag_mismatch("led_ph7", got.led_ph7, want.led_ph7);
                if (got.led_ec !== want.led_ec)
                    flag_mismatch("led_ec", got.led_ec, want.led_ec);
                if (got.led_fail !== want.led_fail)
                    flag_mismatch("led_fail", got.led_fail, want.led_fail);
                if (got.calib_event !== want.calib_event)
                    flag_mismatch("calib_event", got.calib_event, want.calib_event);
                if (got.acid_mv !== want.acid_mv)
                    flag_mismatch("acid_cal_mv", got.acid_mv, want.acid_mv);
                if (got.neutral_mv !== want.neutral_mv)
                    flag_mismatch("neutral_cal_mv", got.neutral_mv, want.neutral_mv);
                if (got.cell_k !== want.cell_k)
                    flag_mismatch("cell_constant", got.cell_k, want.cell_k);
                if (got.store_req !== want.store_req)
                    flag_mismatch("store_request", got.store_req, want.store_req);
                if (got.any_active !== want.any_active)
                    flag_mismatch("any_active", got.any_active, want.any_active);
            end
            n_checked++;
        end
    end

    // Receiver: hold the result side off for a long stretch so the block backs up
    int holdoff_left = 0;
    int n_taken = 0;

    always @(posedge i_clk) begin : receiver
        if (o_valid && !i_stall) begin
            n_taken++;
            if (n_taken == 400 || n_taken == 1700) holdoff_left = 500;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("** sensor_calibration_button_controller_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table (short press 1 ms, long press 2 ms, timeout 2 ms)
    // ------------------------------------------------------------------------
    initial begin
        t_result quiet;
        quiet = bare_result(4'h0, EV_NONE);
        // nothing stored yet after reset
        dir_rows.push_back('{mk_word(OP_TICK, 0, 0, 0, 0, 0), 1'b1, quiet});
        // release with no press, every field set to all ones
        dir_rows.push_back('{mk_word(OP_RELEASE, 4095, 4095, -1, 1, 65535), 1'b1, quiet});
        dir_rows.push_back('{mk_word(OP_UNUSED, 4095, 4095, -1, 1, 65535), 1'b1, quiet});
        dir_rows.push_back('{mk_word(OP_PRESS, 0, 0, -1024, 0, 0), 1'b1, quiet});
        // press during a press restarts the hold
        dir_rows.push_back('{mk_word(OP_PRESS, 0, 0, 2047, 0, 0), 1'b1, quiet});
        dir_rows.push_back('{mk_word(OP_RELEASE, 0, 0, 0, 0, 0), 1'b1,
                             bare_result(4'hF, EV_LED_TEST)});
        // run the LED test timer out
        dir_rows.push_back('{mk_word(OP_TICK, 0, 0, 0, 0, 0), 1'b0, quiet});
        dir_rows.push_back('{mk_word(OP_TICK, 0, 0, 0, 0, 0), 1'b0, quiet});
        // middle holds: pH4 hit, pH7 hit, out of both windows
        for (int k = 0; k < 3; k++) begin
            dir_rows.push_back('{mk_word(OP_PRESS, 0, 0, 0, 0, 0), 1'b0, quiet});
            dir_rows.push_back('{mk_word(OP_TICK, 0, 0, 0, 0, 0), 1'b0, quiet});
            dir_rows.push_back('{mk_word(OP_RELEASE, (k == 0) ? 1490 : (k == 1) ? 1271 : 4095,
                                         0, 0, 0, 0), 1'b0, quiet});
        end
        // long holds: conductivity at 25 C accepted, then reading below range
        for (int k = 0; k < 2; k++) begin
            dir_rows.push_back('{mk_word(OP_PRESS, 0, 0, 0, 0, 0), 1'b0, quiet});
            dir_rows.push_back('{mk_word(OP_TICK, 0, 0, 0, 0, 0), 1'b0, quiet});
            dir_rows.push_back('{mk_word(OP_TICK, 0, 0, 0, 0, 0), 1'b0, quiet});
            dir_rows.push_back('{mk_word(OP_RELEASE, 0, (k == 0) ? 1413 : 299, 400, 0, 16000),
                                 1'b0, quiet});
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words, no idling
        program_config(1, 2, 2, RST_ACID_LOW, RST_ACID_HIGH, RST_NEUT_LOW, RST_NEUT_HIGH);
        foreach (dir_rows[k]) offer(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].r);
        drain();

        // all three actions reachable; the sender idles lightly, the receiver heavily
        send_idle_pct = 16;
        recv_idle_pct = 74;
        program_config(8, 24, 20, RST_ACID_LOW, RST_ACID_HIGH, RST_NEUT_LOW, RST_NEUT_HIGH);
        run_random(700, 32);
        drain();

        // short threshold above long: no hold reaches pH calibration, holds at or
        // past the short threshold go to conductivity; a zero timeout expires on the next tick
        send_idle_pct = 74;
        recv_idle_pct = 16;
        program_config(40, 12, 0, 0, 600, 1500, 3300);
        run_random(700, 50);
        drain();

        // no idling; short threshold of 1, top long threshold and timeout
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_config(1, 65535, 4095, 3300, 3300, 0, 0);
        run_random(550, 12);
        drain();

        // both thresholds at their top: every hold gives the LED test
        program_config(65535, 65535, 1, 4095, 4095, 0, 4095);
        offer(rand_word(OP_PRESS));
        repeat (40) offer(rand_word(OP_TICK));
        offer(release_word());
        run_random(30, 4);
        drain();

        // allow a stray late result to show up
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("** sensor_calibration_button_controller_top: PASSED **");
        else
            $display("** sensor_calibration_button_controller_top: FAILED **");
        $finish;
    end

endmodule
